@@ rtl/core/rcfp_pkg.sv @@
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared types and character constants for the command frame parser.
// ----------------------------------------------------------------------------
package rcfp_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
  localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
  localparam logic [7:0] CH_UC_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UC_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // Largest value that may still take a third digit, and the digit limit at it
  localparam logic [7:0] ACC_EDGE   = 8'd25;
  localparam logic [3:0] DIGIT_EDGE = 4'd5;

  // Classified received word, passed from front to back
  typedef struct packed {
    logic [7:0] raw;
    logic       is_open;
    logic       is_close;
    logic       is_letter;
    logic       is_digit;
    logic [3:0] digit;
  } rx_word_t;

endpackage

@@ rtl/core/rcfp_front.sv @@
// ----------------------------------------------------------------------------
// rcfp_front
// Accepts received words and tags each with its character class.
// ----------------------------------------------------------------------------
module rcfp_front (
  input  logic              push,
  input  logic [7:0]        in_rx_byte,
  input  logic              q_full,
  output logic              q_wr,
  output rcfp_pkg::rx_word_t q_word
);
  import rcfp_pkg::*;

  logic [7:0] dig_off;

  assign dig_off = in_rx_byte - CH_ZERO;

  always_comb begin
    q_word.raw       = in_rx_byte;
    q_word.is_open   = (in_rx_byte == CH_OPEN);
    q_word.is_close  = (in_rx_byte == CH_CLOSE);
    q_word.is_letter = (in_rx_byte >= CH_UC_A) && (in_rx_byte <= CH_UC_Z);
    q_word.is_digit  = (in_rx_byte >= CH_ZERO) && (in_rx_byte <= CH_NINE);
    q_word.digit     = dig_off[3:0];
  end

  assign q_wr = push && !q_full;

endmodule

@@ rtl/core/rcfp_queue.sv @@
// ----------------------------------------------------------------------------
// rcfp_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module rcfp_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr,
  input  rcfp_pkg::rx_word_t wr_word,
  input  logic               rd,
  output rcfp_pkg::rx_word_t rd_word,
  output logic               full,
  output logic               avail
);
  import rcfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  rx_word_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign do_wr = wr && (cnt_r != FULL_CNT);
  assign do_rd = rd && (cnt_r != '0);

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == LAST) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == LAST) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_word;
    end
  end

  assign rd_word = mem_r[rp_r];
  assign full    = (cnt_r == FULL_CNT);
  assign avail   = (cnt_r != '0);

endmodule

@@ rtl/core/rcfp_back.sv @@
// ----------------------------------------------------------------------------
// rcfp_back
// Frame parser state machine with registered result slot.
// ----------------------------------------------------------------------------
module rcfp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_avail,
  input  rcfp_pkg::rx_word_t q_word,
  output logic               q_rd,
  output logic               empty,
  input  logic               pop,
  output logic [6:0]         out_cmd_letter,
  output logic [7:0]         out_cmd_value
);
  import rcfp_pkg::*;

  localparam logic [1:0] PH_OPEN   = 2'd0;
  localparam logic [1:0] PH_LETTER = 2'd1;
  localparam logic [1:0] PH_ARG1   = 2'd2;
  localparam logic [1:0] PH_ARG2   = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [6:0] letter_r, letter_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [1:0] dcnt_r, dcnt_nxt;
  logic [7:0] first_r, first_nxt;
  logic       res_vld_r, res_vld_nxt;
  logic [6:0] res_letter_r, res_letter_nxt;
  logic [7:0] res_value_r, res_value_nxt;

  logic       slot_free;
  logic       take_dig;
  logic       emit;
  logic [7:0] acc_x10;

  // slot frees up when empty or being taken this cycle
  assign slot_free = !res_vld_r || pop;
  assign q_rd      = q_avail && slot_free;

  assign acc_x10 = {acc_r[4:0], 3'b000} + {acc_r[6:0], 1'b0};

  always_comb begin
    take_dig = 1'b0;
    if (q_word.is_digit) begin
      if (dcnt_r < 2'd2) begin
        take_dig = 1'b1;
      end else if (dcnt_r == 2'd2) begin
        take_dig = (acc_r < ACC_EDGE) ||
                   ((acc_r == ACC_EDGE) && (q_word.digit <= DIGIT_EDGE));
      end
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    letter_nxt     = letter_r;
    acc_nxt        = acc_r;
    dcnt_nxt       = dcnt_r;
    first_nxt      = first_r;
    emit           = 1'b0;
    res_letter_nxt = res_letter_r;
    res_value_nxt  = res_value_r;
    if (q_rd) begin
      case (phase_r)
        PH_LETTER: begin
          if (q_word.is_letter) begin
            letter_nxt = q_word.raw[6:0];
            acc_nxt    = '0;
            dcnt_nxt   = '0;
            phase_nxt  = PH_ARG1;
          end else begin
            phase_nxt = PH_OPEN;
          end
        end
        PH_ARG1, PH_ARG2: begin
          if (take_dig) begin
            acc_nxt  = acc_x10 + {4'b0000, q_word.digit};
            dcnt_nxt = dcnt_r + 1'b1;
          end else if (phase_r == PH_ARG1) begin
            if (q_word.raw == {1'b0, letter_r}) begin
              first_nxt = acc_r;
              acc_nxt   = '0;
              dcnt_nxt  = '0;
              phase_nxt = PH_ARG2;
            end else begin
              phase_nxt = PH_OPEN;
            end
          end else begin
            if (q_word.is_close && (acc_r == first_r)) begin
              emit           = 1'b1;
              res_letter_nxt = letter_r;
              res_value_nxt  = acc_r;
            end
            phase_nxt = PH_OPEN;
          end
        end
        default: begin
          phase_nxt = q_word.is_open ? PH_LETTER : PH_OPEN;
        end
      endcase
    end
  end

  always_comb begin
    res_vld_nxt = res_vld_r;
    if (emit) begin
      res_vld_nxt = 1'b1;
    end else if (pop) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_OPEN;
      letter_r  <= '0;
      acc_r     <= '0;
      dcnt_r    <= '0;
      first_r   <= '0;
      res_vld_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      letter_r  <= letter_nxt;
      acc_r     <= acc_nxt;
      dcnt_r    <= dcnt_nxt;
      first_r   <= first_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_letter_r <= res_letter_nxt;
    res_value_r  <= res_value_nxt;
  end

  assign empty          = !res_vld_r;
  assign out_cmd_letter = res_letter_r;
  assign out_cmd_value  = res_value_r;

endmodule

@@ rtl/core/redundant_command_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// redundant_command_frame_parser_core
// Finds frames '<' L A L A '>' in a byte stream and reports verified commands.
// ----------------------------------------------------------------------------
// Usage
//   Input side is a queue: write a received byte on in_rx_byte with push while
//   full is low; one word may be taken every cycle.
//   Result side is a single-entry slot: while empty is low, out_cmd_letter/
//   out_cmd_value hold the verified command; pop takes it.
//   Each byte is tagged by the front end, parked in a QUEUE_DEPTH-word queue,
//   then consumed by the parser state machine at one word per cycle while
//   the result slot is free. With the queue otherwise empty, the closing '>'
//   word is written into the queue when accepted, then the parser step moves
//   it into the result register.
//   Throughput: one word per cycle while results are popped promptly; a
//   held result stalls the parser, the queue absorbs QUEUE_DEPTH words and
//   then full rises.
//   Reset (rst_n low, synchronous) empties queue and result slot and puts
//   the parser back to hunting for '<'.
// ----------------------------------------------------------------------------
module redundant_command_frame_parser_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_cmd_letter,
  output logic [7:0] out_cmd_value
);
  import rcfp_pkg::*;

  rx_word_t fq_word;   // front -> queue
  rx_word_t qb_word;   // queue -> back
  logic     q_wr;
  logic     q_rd;
  logic     q_avail;

  // front: classify and write into the queue
  rcfp_front u_front (
    .push       (push),
    .in_rx_byte (in_rx_byte),
    .q_full     (full),
    .q_wr       (q_wr),
    .q_word     (fq_word)
  );

  // decoupling queue
  rcfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_word (fq_word),
    .rd      (q_rd),
    .rd_word (qb_word),
    .full    (full),
    .avail   (q_avail)
  );

  // back: parser and result slot
  rcfp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_avail        (q_avail),
    .q_word         (qb_word),
    .q_rd           (q_rd),
    .empty          (empty),
    .pop            (pop),
    .out_cmd_letter (out_cmd_letter),
    .out_cmd_value  (out_cmd_value)
  );

  // a new result only ever follows a word taken by the parser
  a_res_from_word: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(empty) |-> $past(q_rd))
    else $error("result appeared without a parsed word");

  // parser never takes a word while an unpopped result blocks the slot
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |-> !q_rd)
    else $error("parser stepped over a held result");

  // a parser read frees a queue place
  a_full_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (full && q_rd) |=> !full)
    else $error("queue stayed full after a read");

endmodule
